FILE: src/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants of the transposed 2x2 convolution engine.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_IN_HEIGHT    = 16;
  localparam int DEF_MAX_IN_WIDTH     = 16;

  localparam int TAPS      = 4;
  localparam int ACC_W     = 40;
  localparam int DIM_W     = 7;
  localparam int REG_W     = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_TWO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PX_RD,
    ST_PX_MUL,
    ST_PX_ACC,
    ST_DR_RD,
    ST_DR_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic wt_we;
    logic clr_step;
    logic px_rd;
    logic px_mul;
    logic px_acc;
    logic dr_rd;
    logic dr_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       pix_ok;
    logic       last;
    logic       clr_done;
    logic       out_free;
  } status_t;

endpackage

FILE: src/tca_if.sv
// ----------------------------------------------------------------------------
// tca_in_if / tca_out_if
// Valid/ready channels for items and drained results.
// ----------------------------------------------------------------------------
interface tca_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [3:0]         in_channel;
  logic [3:0]         out_channel;
  logic [1:0]         tap;
  logic [4:0]         row;
  logic [4:0]         col;
  logic signed [15:0] pixel_value;
  logic signed [15:0] weight_value;

  modport source (output valid, operation, in_channel, out_channel, tap, row, col,
                  pixel_value, weight_value, input ready);
  modport sink (input valid, operation, in_channel, out_channel, tap, row, col,
                pixel_value, weight_value, output ready);
endinterface

interface tca_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] acc_value;
  logic               saturated;

  modport source (output valid, acc_value, saturated, input ready);
  modport sink (input valid, acc_value, saturated, output ready);
endinterface

FILE: src/transposed_conv_2x2_accumulate.sv
// ----------------------------------------------------------------------------
// transposed_conv_2x2_accumulate
// Scatter-accumulate engine for a transposed 2x2 convolution, stride 1 or 2.
// ----------------------------------------------------------------------------
// After reset the output memory is swept clean, one entry per cycle, over all
// MAX_OUT_CHANNELS*4*MAX_IN_HEIGHT*MAX_IN_WIDTH entries (16384 by default);
// no transaction is taken meanwhile. A weight load or an ignored item is taken
// in the idle state. A pixel performs one read-multiply-accumulate per output
// channel and tap through a single multiplier and one output memory port, in
// the read, multiply and accumulate states. A drain reads the entry, then waits
// until the result register is free before loading it and clearing a valid entry.
module transposed_conv_2x2_accumulate #(
  parameter int MAX_IN_CHANNELS  = tca_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = tca_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_IN_HEIGHT    = tca_pkg::DEF_MAX_IN_HEIGHT,
  parameter int MAX_IN_WIDTH     = tca_pkg::DEF_MAX_IN_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tca_pkg::REG_W-1:0]     cfg_data,
  tca_in_if.sink                        in_if,
  tca_out_if.source                     out_if
);

  tca_pkg::cmd_t    cmd;
  tca_pkg::status_t status;

  tca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tca_datapath #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
    .MAX_IN_HEIGHT    (MAX_IN_HEIGHT),
    .MAX_IN_WIDTH     (MAX_IN_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_operation    (in_if.operation),
    .in_in_channel   (in_if.in_channel),
    .in_out_channel  (in_if.out_channel),
    .in_tap          (in_if.tap),
    .in_row          (in_if.row),
    .in_col          (in_if.col),
    .in_pixel_value  (in_if.pixel_value),
    .in_weight_value (in_if.weight_value),
    .cmd             (cmd),
    .status          (status),
    .out_if          (out_if)
  );

`ifndef SYNTHESIS
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.operation == tca_pkg::OP_DRAIN) |=> !in_if.ready)
    else $error("drain transaction did not occupy the engine");

  a_acc_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.px_acc |-> ($past(cmd.px_mul, 1) && $past(cmd.px_rd, 2)))
    else $error("accumulate without read and multiply");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dr_out |-> (!out_if.valid || out_if.ready))
    else $error("pending result overwritten");
`endif

endmodule

FILE: src/tca_ctrl.sv
// ----------------------------------------------------------------------------
// tca_ctrl
// Sequencer: clearing pass, weight loads, per-tap read/multiply/accumulate,
// and drains.
// ----------------------------------------------------------------------------
module tca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tca_pkg::status_t  status,
  output tca_pkg::cmd_t     cmd
);

  tca_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tca_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tca_pkg::ST_CLEAR: begin
        if (status.clr_done) state_nxt = tca_pkg::ST_IDLE;
      end
      tca_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.in_op == tca_pkg::OP_PIXEL && status.pix_ok) begin
            state_nxt = tca_pkg::ST_PX_RD;
          end else if (status.in_op == tca_pkg::OP_DRAIN) begin
            state_nxt = tca_pkg::ST_DR_RD;
          end
        end
      end
      tca_pkg::ST_PX_RD:  state_nxt = tca_pkg::ST_PX_MUL;
      tca_pkg::ST_PX_MUL: state_nxt = tca_pkg::ST_PX_ACC;
      tca_pkg::ST_PX_ACC: begin
        state_nxt = status.last ? tca_pkg::ST_IDLE : tca_pkg::ST_PX_RD;
      end
      tca_pkg::ST_DR_RD:  state_nxt = tca_pkg::ST_DR_OUT;
      tca_pkg::ST_DR_OUT: begin
        if (status.out_free) state_nxt = tca_pkg::ST_IDLE;
      end
      default: state_nxt = tca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tca_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      tca_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.wt_we  = in_valid && (status.in_op == tca_pkg::OP_LOAD);
      end
      tca_pkg::ST_PX_RD:  cmd.px_rd  = 1'b1;
      tca_pkg::ST_PX_MUL: cmd.px_mul = 1'b1;
      tca_pkg::ST_PX_ACC: cmd.px_acc = 1'b1;
      tca_pkg::ST_DR_RD:  cmd.dr_rd  = 1'b1;
      tca_pkg::ST_DR_OUT: cmd.dr_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/tca_datapath.sv
// ----------------------------------------------------------------------------
// tca_datapath
// Configuration registers, weight and output memories, multiplier,
// saturating accumulator and result register.
// ----------------------------------------------------------------------------
module tca_datapath #(
  parameter int MAX_IN_CHANNELS  = tca_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = tca_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_IN_HEIGHT    = tca_pkg::DEF_MAX_IN_HEIGHT,
  parameter int MAX_IN_WIDTH     = tca_pkg::DEF_MAX_IN_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tca_pkg::REG_W-1:0]       cfg_data,
  input  logic [1:0]                      in_operation,
  input  logic [3:0]                      in_in_channel,
  input  logic [3:0]                      in_out_channel,
  input  logic [1:0]                      in_tap,
  input  logic [4:0]                      in_row,
  input  logic [4:0]                      in_col,
  input  logic signed [15:0]              in_pixel_value,
  input  logic signed [15:0]              in_weight_value,
  input  tca_pkg::cmd_t                   cmd,
  output tca_pkg::status_t                status,
  tca_out_if.source                       out_if
);

  localparam int OUT_ROWS = 2 * MAX_IN_HEIGHT;
  localparam int OUT_COLS = 2 * MAX_IN_WIDTH;
  localparam int WDEPTH   = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * tca_pkg::TAPS;
  localparam int ODEPTH   = MAX_OUT_CHANNELS * OUT_ROWS * OUT_COLS;
  localparam int WAW      = $clog2(WDEPTH);
  localparam int OAW      = $clog2(ODEPTH);
  localparam int OCW      = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int AW       = tca_pkg::ACC_W;
  localparam int DW       = tca_pkg::DIM_W;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  logic                   stride_two_r;
  logic [tca_pkg::REG_W-1:0] in_height_r, in_width_r, in_ch_r, out_ch_r;
  logic [DW-1:0]          h, w, icn, ocn, oh, ow;

  logic [3:0]             ic_r, oc_r;
  logic [4:0]             row_r, col_r;
  logic signed [15:0]     pix_r;
  logic                   drain_ok_r;
  logic [OCW-1:0]         o_r;
  logic [1:0]             t_r;
  logic [OAW-1:0]         clr_cnt_r;
  logic [OAW-1:0]         addr_r;

  logic [15:0]            wt_mem [WDEPTH];
  logic [AW:0]            out_mem [ODEPTH];
  logic signed [15:0]     wt_rdata_r;
  logic [AW:0]            out_rdata_r;
  logic signed [31:0]     prod_r;

  logic                   pix_ok, drain_ok, load_ok;
  logic [WAW-1:0]         load_addr, wt_addr;
  logic [OAW-1:0]         px_addr, dr_addr, rd_addr, wr_addr;
  logic [DW:0]            by, bx;
  logic signed [AW:0]     sum;
  logic [AW:0]            wr_data;
  logic                   mem_we;
  logic signed [AW-1:0]   sat_val;
  logic                   sat_hit;

  logic                   out_valid_r;
  logic signed [AW-1:0]   out_acc_r;
  logic                   out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_two_r <= 1'b0;
      in_height_r  <= tca_pkg::REG_W'(16);
      in_width_r   <= tca_pkg::REG_W'(16);
      in_ch_r      <= tca_pkg::REG_W'(16);
      out_ch_r     <= tca_pkg::REG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tca_pkg::CFG_STRIDE_TWO:   stride_two_r <= cfg_data[0];
        tca_pkg::CFG_IN_HEIGHT:    in_height_r  <= cfg_data;
        tca_pkg::CFG_IN_WIDTH:     in_width_r   <= cfg_data;
        tca_pkg::CFG_IN_CHANNELS:  in_ch_r      <= cfg_data;
        tca_pkg::CFG_OUT_CHANNELS: out_ch_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    h   = (32'(in_height_r) > MAX_IN_HEIGHT)    ? DW'(MAX_IN_HEIGHT)    : DW'(in_height_r);
    w   = (32'(in_width_r) > MAX_IN_WIDTH)      ? DW'(MAX_IN_WIDTH)     : DW'(in_width_r);
    icn = (32'(in_ch_r) > MAX_IN_CHANNELS)      ? DW'(MAX_IN_CHANNELS)  : DW'(in_ch_r);
    ocn = (32'(out_ch_r) > MAX_OUT_CHANNELS)    ? DW'(MAX_OUT_CHANNELS) : DW'(out_ch_r);
    oh  = stride_two_r ? DW'({h, 1'b0}) : DW'(h + DW'(1));
    ow  = stride_two_r ? DW'({w, 1'b0}) : DW'(w + DW'(1));
  end

  assign pix_ok   = (DW'(in_in_channel) < icn) && (DW'(in_row) < h) &&
                    (DW'(in_col) < w) && (ocn != '0);
  assign drain_ok = (DW'(in_out_channel) < ocn) && (DW'(in_row) < oh) &&
                    (DW'(in_col) < ow);
  assign load_ok  = (32'(in_in_channel) < MAX_IN_CHANNELS) &&
                    (32'(in_out_channel) < MAX_OUT_CHANNELS);

  assign load_addr = WAW'((32'(in_out_channel) * MAX_IN_CHANNELS + 32'(in_in_channel))
                          * tca_pkg::TAPS + 32'(in_tap));
  assign wt_addr   = WAW'((32'(o_r) * MAX_IN_CHANNELS + 32'(ic_r)) * tca_pkg::TAPS
                          + 32'(t_r));

  assign by      = stride_two_r ? (DW+1)'({row_r, 1'b0}) : (DW+1)'(row_r);
  assign bx      = stride_two_r ? (DW+1)'({col_r, 1'b0}) : (DW+1)'(col_r);
  assign px_addr = OAW'((32'(o_r) * OUT_ROWS + 32'(by) + 32'(t_r[1])) * OUT_COLS
                        + 32'(bx) + 32'(t_r[0]));
  assign dr_addr = OAW'((32'(oc_r) * OUT_ROWS + 32'(row_r)) * OUT_COLS + 32'(col_r));
  assign rd_addr = cmd.px_rd ? px_addr : dr_addr;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ic_r       <= in_in_channel;
      oc_r       <= in_out_channel;
      row_r      <= in_row;
      col_r      <= in_col;
      pix_r      <= in_pixel_value;
      drain_ok_r <= drain_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_r       <= '0;
      t_r       <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.accept) begin
        o_r <= '0;
        t_r <= '0;
      end else if (cmd.px_acc) begin
        t_r <= t_r + 2'd1;
        if (t_r == 2'd3) o_r <= o_r + OCW'(1);
      end
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + OAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wt_we && load_ok) wt_mem[load_addr] <= in_weight_value;
    if (cmd.px_rd) begin
      wt_rdata_r <= wt_mem[wt_addr];
      addr_r     <= px_addr;
    end
    if (cmd.px_rd || cmd.dr_rd) out_rdata_r <= out_mem[rd_addr];
    if (cmd.px_mul) prod_r <= pix_r * wt_rdata_r;
    if (mem_we) out_mem[wr_addr] <= wr_data;
  end

  always_comb begin
    sum     = $signed({out_rdata_r[AW-1], out_rdata_r[AW-1:0]}) + (AW+1)'(prod_r);
    sat_hit = sum[AW] != sum[AW-1];
    sat_val = sat_hit ? (sum[AW] ? ACC_MIN : ACC_MAX) : sum[AW-1:0];
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = dr_addr;
    wr_data = '0;
    priority if (cmd.clr_step) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (cmd.px_acc) begin
      mem_we  = 1'b1;
      wr_addr = addr_r;
      wr_data = {out_rdata_r[AW] | sat_hit, sat_val};
    end else if (cmd.dr_out) begin
      mem_we  = drain_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.dr_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dr_out) begin
      out_acc_r <= drain_ok_r ? out_rdata_r[AW-1:0] : '0;
      out_sat_r <= drain_ok_r & out_rdata_r[AW];
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.acc_value = out_acc_r;
  assign out_if.saturated = out_sat_r;

  assign status.in_op    = in_operation;
  assign status.pix_ok   = pix_ok;
  assign status.last     = (t_r == 2'd3) && (DW'(o_r) + DW'(1) == ocn);
  assign status.clr_done = clr_cnt_r == OAW'(ODEPTH - 1);
  assign status.out_free = !out_valid_r || out_if.ready;

endmodule

FILE: tb/sv/tca_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tca_checker
// Watches the item and result channels of the transposed 2x2 convolution
// engine, keeps its own copy of weights, accumulators and saturation marks,
// and compares every drained result with the predicted one.
// ----------------------------------------------------------------------------
module tca_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [4:0]       cfg_data,
  tca_in_if                in_if,
  tca_out_if               out_if,
  output int               mismatch_count,
  output int               pending_count
);

  typedef struct packed {
    logic signed [39:0] acc_value;
    logic               saturated;
  } drain_t;

  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;

  logic [4:0] stride_reg, height_reg, width_reg, icn_reg, ocn_reg;
  logic signed [15:0] weights [0:1023];
  longint acc_mem [0:16383];
  bit sat_mem [0:16383];
  drain_t drain_queue[$];

  assign pending_count = drain_queue.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic predict_item();
    int h, w, icn, ocn, by, bx, idx, oh, ow;
    longint s;
    drain_t d;
    h = (height_reg < 16) ? height_reg : 16;
    w = (width_reg < 16) ? width_reg : 16;
    icn = (icn_reg < 16) ? icn_reg : 16;
    ocn = (ocn_reg < 16) ? ocn_reg : 16;
    case (in_if.operation)
      tca_pkg::OP_LOAD:
        weights[{in_if.out_channel, in_if.in_channel, in_if.tap}] = in_if.weight_value;
      tca_pkg::OP_PIXEL: begin
        if (in_if.in_channel < icn && in_if.row < h && in_if.col < w) begin
          by = stride_reg[0] ? 2 * in_if.row : in_if.row;
          bx = stride_reg[0] ? 2 * in_if.col : in_if.col;
          for (int o = 0; o < ocn; o++) begin
            for (int t = 0; t < tca_pkg::TAPS; t++) begin
              idx = (o * 32 + by + t / 2) * 32 + bx + t % 2;
              s = acc_mem[idx] + longint'(in_if.pixel_value) *
                  longint'(weights[{o[3:0], in_if.in_channel, t[1:0]}]);
              if (s > ACC_HI) begin
                s = ACC_HI;
                sat_mem[idx] = 1;
              end else if (s < ACC_LO) begin
                s = ACC_LO;
                sat_mem[idx] = 1;
              end
              acc_mem[idx] = s;
            end
          end
        end
      end
      tca_pkg::OP_DRAIN: begin
        oh = stride_reg[0] ? 2 * h : h + 1;
        ow = stride_reg[0] ? 2 * w : w + 1;
        if (in_if.out_channel >= ocn || in_if.row >= oh || in_if.col >= ow) begin
          d = '0;
        end else begin
          idx = (in_if.out_channel * 32 + in_if.row) * 32 + in_if.col;
          d.acc_value = acc_mem[idx][39:0];
          d.saturated = sat_mem[idx];
          acc_mem[idx] = 0;
          sat_mem[idx] = 0;
        end
        drain_queue.push_back(d);
      end
      default: ;
    endcase
  endtask

  initial begin
    mismatch_count = 0;
    foreach (acc_mem[i]) begin
      acc_mem[i] = 0;
      sat_mem[i] = 0;
    end
  end

  always @(posedge clk) begin
    drain_t d;
    if (!rst_n) begin
      stride_reg <= 5'd0;
      height_reg <= 5'd16;
      width_reg <= 5'd16;
      icn_reg <= 5'd16;
      ocn_reg <= 5'd16;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (drain_queue.size() == 0) begin
          report("unexpected transaction", out_if.acc_value, 0);
        end else begin
          d = drain_queue.pop_front();
          if (out_if.acc_value !== d.acc_value)
            report("acc_value", out_if.acc_value, d.acc_value);
          if (out_if.saturated !== d.saturated)
            report("saturated", out_if.saturated, d.saturated);
        end
      end
      if (in_if.valid && in_if.ready) predict_item();
      if (cfg_we) begin
        case (cfg_index)
          tca_pkg::CFG_STRIDE_TWO:   stride_reg <= {4'd0, cfg_data[0]};
          tca_pkg::CFG_IN_HEIGHT:    height_reg <= cfg_data;
          tca_pkg::CFG_IN_WIDTH:     width_reg <= cfg_data;
          tca_pkg::CFG_IN_CHANNELS:  icn_reg <= cfg_data;
          tca_pkg::CFG_OUT_CHANNELS: ocn_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives weight loads, pixels and drains into the transposed 2x2 convolution
// engine over several stride and size settings, with random idling on both
// channels, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [tca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tca_pkg::REG_W-1:0] cfg_data = '0;
  int mismatch_count, pending_count;
  bit no_idle = 0;

  tca_in_if in_if ();
  tca_out_if out_if ();

  transposed_conv_2x2_accumulate i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_if(in_if), .out_if(out_if));

  tca_checker i_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_if(in_if), .out_if(out_if),
    .mismatch_count(mismatch_count), .pending_count(pending_count));

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 0;
    in_if.operation = tca_pkg::OP_LOAD;
    in_if.in_channel = 0;
    in_if.out_channel = 0;
    in_if.tap = 0;
    in_if.row = 0;
    in_if.col = 0;
    in_if.pixel_value = 0;
    in_if.weight_value = 0;
    out_if.ready = 0;
  end

  always @(posedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 34);
  end

  task automatic send(input logic [1:0] op, input int ic, input int oc, input int tp,
                      input int r, input int c, input int pv, input int wv);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_if.valid <= 0;
      @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.operation <= op;
    in_if.in_channel <= 4'(ic);
    in_if.out_channel <= 4'(oc);
    in_if.tap <= 2'(tp);
    in_if.row <= 5'(r);
    in_if.col <= 5'(c);
    in_if.pixel_value <= 16'(pv);
    in_if.weight_value <= 16'(wv);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tca_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= tca_pkg::REG_W'(val);
    @(posedge clk);
  endtask

  // load every tap of the channel pairs in use so no pixel reads an unwritten weight
  task automatic load_all(input int mode, input int ocn, input int icn);
    int wv;
    for (int oc = 0; oc < ocn; oc++)
      for (int ic = 0; ic < icn; ic++)
        for (int t = 0; t < tca_pkg::TAPS; t++) begin
          case (mode)
            0: wv = -32768;
            1: wv = 32767;
            default: wv = $urandom_range(65535);
          endcase
          send(tca_pkg::OP_LOAD, ic, oc, t, 0, 0, 0, wv);
        end
  endtask

  task automatic setup(input int s2, input int h, input int w, input int icn, input int ocn);
    settle();
    write_reg(tca_pkg::CFG_STRIDE_TWO, s2);
    write_reg(tca_pkg::CFG_IN_HEIGHT, h);
    write_reg(tca_pkg::CFG_IN_WIDTH, w);
    write_reg(tca_pkg::CFG_IN_CHANNELS, icn);
    write_reg(tca_pkg::CFG_OUT_CHANNELS, ocn);
    cfg_we <= 0;
  endtask

  task automatic random_phase(input int count, input int s2, input int h, input int w);
    int op, oh, ow;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(99);
      oh = s2 ? 2 * h : h + 1;
      ow = s2 ? 2 * w : w + 1;
      if (op < 45)
        send(tca_pkg::OP_PIXEL, $urandom_range(15), $urandom_range(15), $urandom_range(3),
             (op < 40) ? $urandom_range(h - 1) : $urandom_range(31),
             (op < 40) ? $urandom_range(w - 1) : $urandom_range(31),
             $urandom_range(65535), $urandom_range(65535));
      else if (op < 85)
        send(tca_pkg::OP_DRAIN, $urandom_range(15), $urandom_range(15), $urandom_range(3),
             (op < 80) ? $urandom_range(oh - 1) : $urandom_range(31),
             (op < 80) ? $urandom_range(ow - 1) : $urandom_range(31),
             $urandom_range(65535), $urandom_range(65535));
      else if (op < 95)
        send(tca_pkg::OP_LOAD, $urandom_range(15), $urandom_range(15), $urandom_range(3),
             $urandom_range(31), $urandom_range(31), $urandom_range(65535),
             $urandom_range(65535));
      else
        send(OP_UNUSED, $urandom_range(15), $urandom_range(15), $urandom_range(3),
             $urandom_range(31), $urandom_range(31), $urandom_range(65535),
             $urandom_range(65535));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    setup(0, 2, 2, 2, 1);
    no_idle = 1;
    load_all(1, 1, 2);
    no_idle = 0;
    send(tca_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 32767, 0);
    send(tca_pkg::OP_PIXEL, 1, 0, 0, 1, 1, -32768, 0);
    send(tca_pkg::OP_PIXEL, 2, 0, 0, 0, 0, 1, 0);
    send(tca_pkg::OP_PIXEL, 0, 0, 0, 2, 0, 1, 0);
    send(tca_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0, 0);
    send(tca_pkg::OP_DRAIN, 0, 0, 0, 2, 2, 0, 0);
    send(tca_pkg::OP_DRAIN, 0, 1, 0, 0, 0, 0, 0);
    send(tca_pkg::OP_DRAIN, 0, 0, 0, 3, 0, 0, 0);
    send(tca_pkg::OP_DRAIN, 0, 15, 0, 31, 31, 0, 0);
    send(OP_UNUSED, 15, 15, 3, 31, 31, -1, -1);
    setup(1, 1, 1, 1, 1);
    for (int k = 0; k < 40; k++) send(tca_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 32767, 0);
    for (int y = 0; y < 2; y++)
      for (int x = 0; x < 2; x++) send(tca_pkg::OP_DRAIN, 0, 0, 0, y, x, 0, 0);
    settle();
    send(tca_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0, 0);
    setup(0, 3, 2, 4, 2);
    load_all(0, 3, 4);
    random_phase(300, 0, 3, 2);
    setup(1, 2, 3, 3, 3);
    no_idle = 1;
    random_phase(300, 1, 2, 3);
    no_idle = 0;
    setup(0, 31, 31, 31, 1);
    load_all(2, 2, 16);
    random_phase(120, 0, 16, 16);
    setup(1, 16, 16, 16, 1);
    load_all(1, 1, 16);
    random_phase(300, 1, 16, 16);
    setup(0, 16, 16, 2, 16);
    load_all(2, 16, 2);
    random_phase(30, 0, 16, 16);
    setup(0, 0, 0, 0, 0);
    random_phase(30, 0, 1, 1);
    setup(1, 5, 4, 16, 2);
    random_phase(300, 1, 5, 4);
    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: sim.f
src/tca_pkg.sv
src/tca_if.sv
src/tca_ctrl.sv
src/tca_datapath.sv
src/transposed_conv_2x2_accumulate.sv
tb/sv/tca_checker.sv
tb/sv/testbench.sv
